[rtl/bbpl_pkg.sv]
package bbpl_pkg;

  // Width of the linear chunk index
  localparam int IDX_W = 32;
  // Default width of grid sizes, counts and origins
  localparam int GRID_BITS_DEF = 16;
  // Configuration register index width
  localparam int CFG_IDX_W = 3;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS  = 3'd0,
    REG_GRID_COLS  = 3'd1,
    REG_ROW_CHUNKS = 3'd2,
    REG_COL_CHUNKS = 3'd3,
    REG_ROW_ORIGIN = 3'd4,
    REG_COL_ORIGIN = 3'd5
  } cfg_reg_t;

endpackage

[rtl/bbpl_if.sv]
interface bbpl_in_if #(parameter int IdxW = bbpl_pkg::IDX_W) ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] chunk_index;
  modport source (output valid, chunk_index, input ready);
  modport sink   (input valid, chunk_index, output ready);
endinterface

interface bbpl_out_if #(parameter int GridBits = bbpl_pkg::GRID_BITS_DEF) ();
  logic                valid;
  logic                ready;
  logic [GridBits-1:0] chunk_rows;
  logic [GridBits-1:0] chunk_cols;
  logic [GridBits:0]   row_offset;
  logic [GridBits:0]   col_offset;
  logic                index_valid;
  modport source (output valid, chunk_rows, chunk_cols, row_offset, col_offset,
                  index_valid, input ready);
  modport sink   (input valid, chunk_rows, chunk_cols, row_offset, col_offset,
                  index_valid, output ready);
endinterface

[rtl/bbpl_locate.sv]
// Extent and origin-adjusted offset of chunk k along one dimension.
// Three register stages: compare/select, multiply, saturating sums.
module bbpl_locate #(
  parameter int GRID_BITS = bbpl_pkg::GRID_BITS_DEF,
  parameter int IDX_W     = bbpl_pkg::IDX_W
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [IDX_W-1:0]     k,
  input  logic [GRID_BITS-1:0] base,
  input  logic [GRID_BITS-1:0] split,
  input  logic [GRID_BITS-1:0] origin,
  output logic [GRID_BITS-1:0] ext,
  output logic [GRID_BITS:0]   ofs
);
  localparam int G = GRID_BITS;
  localparam logic [G:0] OFS_MAX = '1;
  localparam logic [G-1:0] EXT_MAX = '1;

  // stage A
  logic             a_lt;
  logic [IDX_W-1:0] a_sel;
  logic [IDX_W-1:0] a_d;
  logic [G-1:0]     a_base;
  logic [G:0]       a_b1;
  // stage B
  logic               b_lt;
  logic [G-1:0]       b_base;
  logic [G:0]         b_b1;
  logic [G+IDX_W-1:0] b_p1;
  logic [G+IDX_W:0]   b_p2;
  // stage C combinational
  logic [G:0]   c1, c2, s1;
  logic [G+1:0] sum, tot;

  logic [IDX_W-1:0] split_x;
  assign split_x = IDX_W'(split);

  // Stage A: which side of the split, and the multiplicands
  always_ff @(posedge clk) begin
    if (en) begin
      a_lt   <= k < split_x;
      a_sel  <= (k < split_x) ? k : split_x;
      a_d    <= k - split_x;
      a_base <= base;
      a_b1   <= {1'b0, base} + (G+1)'(1);
    end
  end

  // Stage B: products; second term only past the split
  always_ff @(posedge clk) begin
    if (en) begin
      b_lt   <= a_lt;
      b_base <= a_base;
      b_b1   <= a_b1;
      b_p1   <= (G+IDX_W)'(a_base) * (G+IDX_W)'(a_sel);
      b_p2   <= a_lt ? '0 : (G+IDX_W+1)'(a_b1) * (G+IDX_W+1)'(a_d);
    end
  end

  // Stage C: clamp each term, add, add origin, clamp again
  always_comb begin
    c1  = (|b_p1[G+IDX_W-1:G+1]) ? OFS_MAX : b_p1[G:0];
    c2  = (|b_p2[G+IDX_W:G+1]) ? OFS_MAX : b_p2[G:0];
    sum = {1'b0, c1} + {1'b0, c2};
    s1  = sum[G+1] ? OFS_MAX : sum[G:0];
    tot = {1'b0, s1} + (G+2)'(origin);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ext <= b_lt ? b_base : (b_b1[G] ? EXT_MAX : b_b1[G-1:0]);
      ofs <= tot[G+1] ? OFS_MAX : tot[G:0];
    end
  end

endmodule

[rtl/balanced_block_partition_locator.sv]
// Balanced 2D block-partition locator.
// in_ch carries a linear chunk index (row-major over the chunk array); out_ch
// returns the chunk's row/column extent, its first row/column plus the
// configured origin, and index_valid (index below row_chunks * col_chunks).
// Registers are written through cfg_we / cfg_idx / cfg_data; the user must
// write them only while no item is in flight (the block does not enforce it).
// Indexes above 5 are ignored, a chunk count of 0 acts as 1. The pipeline has
// one capture stage, one restoring-divider stage per index bit (the grid-size
// divisions run in the first GRID_BITS of those stages) and three stages of
// multiply and saturating add per dimension. One item per cycle unless stalled.
// The whole pipeline moves as one: when out_ch holds a result that is not
// taken, every stage holds and in_ch.ready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the register defaults
// (1x1 grid, 1x1 chunks, zero origin); no clearing pass is needed.
module balanced_block_partition_locator #(
  parameter int GRID_BITS = bbpl_pkg::GRID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bbpl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [GRID_BITS-1:0]           cfg_data,
  bbpl_in_if.sink                        in_ch,
  bbpl_out_if.source                     out_ch
);
  import bbpl_pkg::*;

  localparam int G  = GRID_BITS;
  localparam int D  = IDX_W;
  localparam int CW = IDX_W + 2 * GRID_BITS;

  typedef struct packed {
    logic [D-1:0] q;   // index bits shifting out, quotient shifting in
    logic [G-1:0] r;   // index remainder
    logic [G-1:0] rq;  // grid_rows / row count
    logic [G-1:0] rr;
    logic [G-1:0] cq;  // grid_cols / col count
    logic [G-1:0] cr;
    logic         iv;  // index in range
  } stage_t;

  logic [G-1:0] grid_rows, grid_cols, row_chunks, col_chunks, row_origin, col_origin;
  logic [G-1:0] rc_e, cc_e;
  logic         en;

  stage_t       pipe [0:D];
  stage_t       nxt  [1:D];
  logic [D:0]   vld;
  logic [2*G-1:0] s0_prod;
  logic [2:0]   vld_l;
  logic [2:0]   iv_l;

  assign rc_e = (row_chunks == '0) ? G'(1) : row_chunks;
  assign cc_e = (col_chunks == '0) ? G'(1) : col_chunks;

  // Pipeline advance
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows  <= G'(1);
      grid_cols  <= G'(1);
      row_chunks <= G'(1);
      col_chunks <= G'(1);
      row_origin <= '0;
      col_origin <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GRID_ROWS:  grid_rows  <= cfg_data;
        REG_GRID_COLS:  grid_cols  <= cfg_data;
        REG_ROW_CHUNKS: row_chunks <= cfg_data;
        REG_COL_CHUNKS: col_chunks <= cfg_data;
        REG_ROW_ORIGIN: row_origin <= cfg_data;
        REG_COL_ORIGIN: col_origin <= cfg_data;
        default: ;
      endcase
    end
  end

  // One restoring-division bit per stage; grid lanes in the first G stages
  always_comb begin
    logic [G:0] tr, gr;
    logic       ge;
    for (int s = 0; s < D; s++) begin
      nxt[s+1] = pipe[s];
      tr = {pipe[s].r, pipe[s].q[D-1]};
      ge = tr >= {1'b0, cc_e};
      tr = ge ? tr - {1'b0, cc_e} : tr;
      nxt[s+1].r = tr[G-1:0];
      nxt[s+1].q = {pipe[s].q[D-2:0], ge};
      if (s < G) begin
        gr = {pipe[s].rr, pipe[s].rq[G-1]};
        ge = gr >= {1'b0, rc_e};
        gr = ge ? gr - {1'b0, rc_e} : gr;
        nxt[s+1].rr = gr[G-1:0];
        nxt[s+1].rq = {pipe[s].rq[G-2:0], ge};
        gr = {pipe[s].cr, pipe[s].cq[G-1]};
        ge = gr >= {1'b0, cc_e};
        gr = ge ? gr - {1'b0, cc_e} : gr;
        nxt[s+1].cr = gr[G-1:0];
        nxt[s+1].cq = {pipe[s].cq[G-2:0], ge};
      end
      if (s == 0) begin
        nxt[s+1].iv = CW'(pipe[0].q) < CW'(s0_prod);
      end
    end
  end

  // Capture stage and divider stages
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].q  <= in_ch.chunk_index;
      pipe[0].r  <= '0;
      pipe[0].rq <= grid_rows;
      pipe[0].rr <= '0;
      pipe[0].cq <= grid_cols;
      pipe[0].cr <= '0;
      pipe[0].iv <= 1'b0;
      s0_prod    <= (2*G)'(rc_e) * (2*G)'(cc_e);
      for (int s = 1; s <= D; s++) begin
        pipe[s] <= nxt[s];
      end
    end
  end

  // Valid bits through divider and locate stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_l <= '0;
    end else if (en) begin
      vld   <= {vld[D-1:0], in_ch.valid};
      vld_l <= {vld_l[1:0], vld[D]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iv_l <= {iv_l[1:0], pipe[D].iv};
    end
  end

  // Per-dimension extent and offset
  bbpl_locate #(.GRID_BITS(G), .IDX_W(D)) u_row (
    .clk    (clk),
    .en     (en),
    .k      (pipe[D].q),
    .base   (pipe[D].rq),
    .split  (rc_e - pipe[D].rr),
    .origin (row_origin),
    .ext    (out_ch.chunk_rows),
    .ofs    (out_ch.row_offset)
  );

  bbpl_locate #(.GRID_BITS(G), .IDX_W(D)) u_col (
    .clk    (clk),
    .en     (en),
    .k      (D'(pipe[D].r)),
    .base   (pipe[D].cq),
    .split  (cc_e - pipe[D].cr),
    .origin (col_origin),
    .ext    (out_ch.chunk_cols),
    .ofs    (out_ch.col_offset)
  );

  assign out_ch.valid       = vld_l[2];
  assign out_ch.index_valid = iv_l[2];

  // Checks
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid) else $error("ready low without a held result");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid) else $error("result valid after reset");
  a_idx_rem: assert property (@(posedge clk) disable iff (rst)
    vld[D] |-> pipe[D].r < cc_e) else $error("index remainder not below count");
  a_row_rem: assert property (@(posedge clk) disable iff (rst)
    vld[D] |-> (pipe[D].rr < rc_e && pipe[D].cr < cc_e))
    else $error("grid remainder not below count");

endmodule
